// ===== src/ildl_pkg.sv =====
// Types, codes and constants shared by the log density lookup modules.
`default_nettype none

package ildl_pkg;

   localparam logic       CMD_WRITE          = 1'b0;
   localparam logic       CMD_QUERY          = 1'b1;
   localparam logic [1:0] STATUS_WRITE       = 2'd0;
   localparam logic [1:0] STATUS_VALID       = 2'd1;
   localparam logic [1:0] STATUS_ZERO        = 2'd2;
   localparam logic [11:0] TICK_COUNT_RESET  = 12'd2000;
   localparam logic [32:0] LN2_Q32           = 33'd2977044472;
   localparam int          LOG_FRAC_BITS     = 24;
   localparam int          DIV_STEPS         = 32;

   typedef struct packed {
      logic               command;
      logic [10:0]        entry_index;
      logic signed [31:0] tick_position;
      logic [31:0]        density_value;
      logic signed [31:0] query_position;
   } req_type;

   typedef struct packed {
      logic signed [20:0] log_density;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_FIRST, ST_LAST, ST_SCAN, ST_MUL_A, ST_MUL_B, ST_DIV_INIT,
      ST_DIV, ST_QUOT, ST_CHECK, ST_NORM, ST_SQ, ST_LN, ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_ACCEPT, OP_TAKE_RD, OP_SCAN_INIT, OP_SCAN_STEP, OP_SCAN_HIT,
      OP_MUL_A, OP_MUL_B, OP_DIV_INIT, OP_DIV_STEP, OP_TAKE_QUOT, OP_NORM_STEP,
      OP_SQ_STEP, OP_LN_MUL
   } op_type;

   typedef enum logic [1:0] {RD_ZERO, RD_LAST, RD_LAST_M1, RD_SCAN} rd_sel_type;

   typedef struct packed {
      op_type     op;
      rd_sel_type rd_sel;
      logic       rsp_load;
      logic [1:0] rsp_status;
   } cmd_type;

   typedef struct packed {
      logic x_le_first;
      logic x_ge_last;
      logic bin_hit;
      logic scan_end;
      logic div_last;
      logic sq_last;
      logic fx_zero;
      logic norm_done;
   } stat_type;

endpackage

`default_nettype wire

// ===== src/ildl_dpath.sv =====
// Datapath: table memories, bin scan registers, shared multiplier, divider and log unit.
`default_nettype none

module ildl_dpath #(
   parameter int TABLE_DEPTH = 2048
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ildl_pkg::req_type req_payload,
   input  wire logic              csr_write_enable,
   input  wire logic [11:0]       csr_write_data,
   input  wire ildl_pkg::cmd_type cmd,
   output ildl_pkg::stat_type     stat,
   output ildl_pkg::rsp_type      rsp_payload
);
   import ildl_pkg::*;

   localparam int IW = $clog2(TABLE_DEPTH);

   logic [31:0]        pos_mem [TABLE_DEPTH];
   logic [31:0]        den_mem [TABLE_DEPTH];

   logic [11:0]        tick_count_ff;
   logic signed [31:0] pos_rd_ff, x_ff, a_ff, b_ff;
   logic [31:0]        den_rd_ff, fa_ff, fb_ff;
   logic [IW-1:0]      j_ff;
   logic signed [65:0] prod_ff;
   logic [63:0]        acc_ff;
   logic [31:0]        rem_ff, q_ff, m_ff, m_in;
   logic [4:0]         p_ff, cnt_ff;
   logic [23:0]        frac_ff;
   rsp_type            rsp_ff;

   logic [31:0]        n_ext, last_wide, idx_ext;
   logic [IW-1:0]      last_idx, raddr;
   logic               mem_we;
   logic [31:0]        bmx, xma, span;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p, rnd;
   logic signed [29:0] lg;
   logic [32:0]        sq, trial, span_ext;
   logic               trial_ge;
   logic [63:0]        num;

   // clamp the grid count into the usable range
   always_comb begin
      n_ext = {20'b0, tick_count_ff};
      if (n_ext < 32'd2) begin
         last_wide = 32'd1;
      end else if (n_ext > 32'(TABLE_DEPTH)) begin
         last_wide = 32'(TABLE_DEPTH - 1);
      end else begin
         last_wide = n_ext - 32'd1;
      end
      last_idx = last_wide[IW-1:0];
   end

   assign idx_ext = {21'b0, req_payload.entry_index};
   assign mem_we  = (cmd.op == OP_ACCEPT) && (req_payload.command == CMD_WRITE)
                    && (idx_ext < 32'(TABLE_DEPTH));

   always_comb begin
      unique case (cmd.rd_sel)
         RD_ZERO:    raddr = '0;
         RD_LAST:    raddr = last_idx;
         RD_LAST_M1: raddr = last_idx - IW'(1);
         RD_SCAN:    raddr = j_ff - IW'(2);
         default:    raddr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pos_mem[idx_ext[IW-1:0]] <= req_payload.tick_position;
         den_mem[idx_ext[IW-1:0]] <= req_payload.density_value;
      end
      pos_rd_ff <= pos_mem[raddr];
      den_rd_ff <= den_mem[raddr];
   end

   // differences fit in 32 unsigned bits because a <= x < b
   assign bmx  = 32'(b_ff - x_ff);
   assign xma  = 32'(x_ff - a_ff);
   assign span = 32'(b_ff - a_ff);
   assign lg   = {({1'b0, p_ff} - 6'd16), frac_ff};

   always_comb begin
      case (cmd.op)
         OP_MUL_A: begin
            mul_a = {1'b0, bmx};
            mul_b = {1'b0, fa_ff};
         end
         OP_MUL_B: begin
            mul_a = {1'b0, xma};
            mul_b = {1'b0, fb_ff};
         end
         OP_SQ_STEP: begin
            mul_a = {1'b0, m_ff};
            mul_b = {1'b0, m_ff};
         end
         default: begin
            mul_a = 33'(lg);
            mul_b = LN2_Q32;
         end
      endcase
   end

   assign mul_p    = mul_a * mul_b;
   assign sq       = mul_p[63:31];
   assign num      = acc_ff + prod_ff[63:0] + {33'b0, span[31:1]};
   assign span_ext = {1'b0, span};
   assign trial_ge = {rem_ff, q_ff[31]} >= span_ext;
   assign trial    = {rem_ff, q_ff[31]} - span_ext;
   assign rnd      = prod_ff + 66'sd549755813888;

   always_comb begin
      case (cmd.op)
         OP_TAKE_RD:   m_in = den_rd_ff;
         OP_TAKE_QUOT: m_in = q_ff;
         OP_NORM_STEP: m_in = {m_ff[30:0], 1'b0};
         OP_SQ_STEP:   m_in = sq[32] ? sq[32:1] : sq[31:0];
         default:      m_in = m_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= TICK_COUNT_RESET;
      end else if (csr_write_enable) begin
         tick_count_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.op == OP_DIV_STEP || cmd.op == OP_SQ_STEP) begin
         cnt_ff <= cnt_ff + 5'd1;
      end else begin
         cnt_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in;
      case (cmd.op)
         OP_ACCEPT:    x_ff <= req_payload.query_position;
         OP_TAKE_RD,
         OP_TAKE_QUOT: p_ff <= 5'd31;
         OP_SCAN_INIT: begin
            b_ff  <= pos_rd_ff;
            fb_ff <= den_rd_ff;
            j_ff  <= last_idx;
         end
         OP_SCAN_STEP: begin
            b_ff  <= pos_rd_ff;
            fb_ff <= den_rd_ff;
            j_ff  <= j_ff - IW'(1);
         end
         OP_SCAN_HIT: begin
            a_ff  <= pos_rd_ff;
            fa_ff <= den_rd_ff;
         end
         OP_MUL_A:     prod_ff <= mul_p;
         OP_MUL_B: begin
            acc_ff  <= prod_ff[63:0];
            prod_ff <= mul_p;
         end
         OP_DIV_INIT: begin
            rem_ff <= num[63:32];
            q_ff   <= num[31:0];
         end
         OP_DIV_STEP: begin
            rem_ff <= trial_ge ? trial[31:0] : {rem_ff[30:0], q_ff[31]};
            q_ff   <= {q_ff[30:0], trial_ge};
         end
         OP_NORM_STEP: p_ff <= p_ff - 5'd1;
         OP_SQ_STEP:   frac_ff <= {frac_ff[22:0], sq[32]};
         OP_LN_MUL:    prod_ff <= mul_p;
         default: ;
      endcase
      if (cmd.op == OP_TAKE_RD || cmd.op == OP_TAKE_QUOT) begin
         frac_ff <= '0;
      end
      if (cmd.rsp_load) begin
         rsp_ff.status      <= cmd.rsp_status;
         rsp_ff.log_density <= (cmd.rsp_status == STATUS_VALID) ? rnd[60:40] : '0;
      end
   end

   assign stat.x_le_first = x_ff <= pos_rd_ff;
   assign stat.x_ge_last  = x_ff >= pos_rd_ff;
   assign stat.bin_hit    = (x_ff >= pos_rd_ff) && (x_ff < b_ff);
   assign stat.scan_end   = j_ff == IW'(1);
   assign stat.div_last   = cnt_ff == 5'(DIV_STEPS - 1);
   assign stat.sq_last    = cnt_ff == 5'(LOG_FRAC_BITS - 1);
   assign stat.fx_zero    = m_ff == '0;
   assign stat.norm_done  = m_ff[31];
   assign rsp_payload     = rsp_ff;

endmodule

`default_nettype wire

// ===== src/ildl_ctrl.sv =====
// Controller: sequences write, bin scan, interpolation, divide and log steps.
`default_nettype none

module ildl_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_command,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   input  wire ildl_pkg::stat_type stat,
   output ildl_pkg::cmd_type       cmd
);
   import ildl_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] status_ff, status_in;
   logic       rsp_valid_ff, accept, slot_free;

   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_WRITE) begin
                  state_in  = ST_DONE;
                  status_in = STATUS_WRITE;
               end else begin
                  state_in = ST_FIRST;
               end
            end
         end
         ST_FIRST:    state_in = stat.x_le_first ? ST_CHECK : ST_LAST;
         ST_LAST:     state_in = stat.x_ge_last ? ST_CHECK : ST_SCAN;
         ST_SCAN: begin
            if (stat.bin_hit) begin
               state_in = ST_MUL_A;
            end else if (stat.scan_end) begin
               state_in  = ST_DONE;
               status_in = STATUS_ZERO;
            end
         end
         ST_MUL_A:    state_in = ST_MUL_B;
         ST_MUL_B:    state_in = ST_DIV_INIT;
         ST_DIV_INIT: state_in = ST_DIV;
         ST_DIV:      state_in = stat.div_last ? ST_QUOT : ST_DIV;
         ST_QUOT:     state_in = ST_CHECK;
         ST_CHECK: begin
            if (stat.fx_zero) begin
               state_in  = ST_DONE;
               status_in = STATUS_ZERO;
            end else begin
               state_in = ST_NORM;
            end
         end
         ST_NORM:     state_in = stat.norm_done ? ST_SQ : ST_NORM;
         ST_SQ:       state_in = stat.sq_last ? ST_LN : ST_SQ;
         ST_LN: begin
            state_in  = ST_DONE;
            status_in = STATUS_VALID;
         end
         ST_DONE:     state_in = slot_free ? ST_IDLE : ST_DONE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op         = OP_NONE;
      cmd.rd_sel     = RD_ZERO;
      cmd.rsp_load   = 1'b0;
      cmd.rsp_status = status_ff;
      unique case (state_ff)
         ST_IDLE:     cmd.op = accept ? OP_ACCEPT : OP_NONE;
         ST_FIRST: begin
            cmd.op     = stat.x_le_first ? OP_TAKE_RD : OP_NONE;
            cmd.rd_sel = RD_LAST;
         end
         ST_LAST: begin
            cmd.op     = stat.x_ge_last ? OP_TAKE_RD : OP_SCAN_INIT;
            cmd.rd_sel = RD_LAST_M1;
         end
         ST_SCAN: begin
            cmd.op     = stat.bin_hit ? OP_SCAN_HIT : OP_SCAN_STEP;
            cmd.rd_sel = RD_SCAN;
         end
         ST_MUL_A:    cmd.op = OP_MUL_A;
         ST_MUL_B:    cmd.op = OP_MUL_B;
         ST_DIV_INIT: cmd.op = OP_DIV_INIT;
         ST_DIV:      cmd.op = OP_DIV_STEP;
         ST_QUOT:     cmd.op = OP_TAKE_QUOT;
         ST_CHECK:    cmd.op = OP_NONE;
         ST_NORM:     cmd.op = stat.norm_done ? OP_NONE : OP_NORM_STEP;
         ST_SQ:       cmd.op = OP_SQ_STEP;
         ST_LN:       cmd.op = OP_LN_MUL;
         ST_DONE:     cmd.rsp_load = slot_free;
         default:     cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         status_ff    <= STATUS_WRITE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while held");
   a_write_done: assert property (@(posedge clock) disable iff (reset)
      accept && (req_command == CMD_WRITE) |=> state_ff == ST_DONE)
      else $error("write item did not go straight to result");
   a_scan_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> $past(state_ff) == ST_LAST || $past(state_ff) == ST_SCAN)
      else $error("scan entered from wrong state");

endmodule

`default_nettype wire

// ===== src/interpolated_log_density_lookup.sv =====
// Top level: piecewise linear density table lookup with fixed point natural log.
//
//   port group   direction  handshake          payload
//   req_*        in         req_valid/stall    ildl_pkg::req_type
//   rsp_*        out        rsp_valid/stall    ildl_pkg::rsp_type
//   csr_*        in         csr_write_enable   12-bit grid count
//
// From acceptance to result: a write goes straight to the result. A query at or below the
// first point or at or above the last takes that density; one inside the grid scans bins
// top down one per cycle, then does two multiplies and a 32-step divide. The log then takes
// up to 31 normalize shifts and 24 squarings; a zero density gets no log and ends early.
// Reset clears control state and sets the grid count to 2000; the table is not cleared.
// One item is in work at a time; a finished item waits while the previous result is held.
`default_nettype none

module interpolated_log_density_lookup #(
   parameter int TABLE_DEPTH = 2048
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ildl_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ildl_pkg::rsp_type      rsp_payload,
   input  wire logic              csr_write_enable,
   input  wire logic [11:0]       csr_write_data
);
   import ildl_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ildl_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_payload.command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .stat        (stat),
      .cmd         (cmd)
   );

   ildl_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_payload      (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== sim/tb_interpolated_log_density_lookup.sv =====
// Self-checking testbench for the interpolated log density lookup block.
`default_nettype none

module tb_interpolated_log_density_lookup;
   timeunit 1ns;
   timeprecision 1ps;

   import ildl_pkg::*;

   localparam int DEPTH       = 2048;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int RANDOM_GOAL = 1250;

   class density_scoreboard;
      logic [31:0] grid_ticks [DEPTH];
      logic [31:0] grid_dens [DEPTH];
      logic [11:0] count_reg;
      rsp_type     expected_q[$];
      int          errors;
      int          n_write;
      int          n_query;
      int          n_zero;

      function new();
         count_reg = TICK_COUNT_RESET;
         errors    = 0;
         n_write   = 0;
         n_query   = 0;
         n_zero    = 0;
         foreach (grid_ticks[i]) begin
            grid_ticks[i] = '0;
            grid_dens[i]  = '0;
         end
      endfunction

      function void set_count(logic [11:0] v);
         count_reg = v;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function int active_count();
         int n;
         n = count_reg;
         if (n < 2) n = 2;
         if (n > DEPTH) n = DEPTH;
         return n;
      endfunction

      // ln(fx / 2^16) in signed Q5.16 via log2 by repeated squaring
      function logic [20:0] ln_q16(logic [31:0] fx);
         int        p;
         bit [63:0] m;
         bit [63:0] frac;
         longint    lg;
         longint    prod;
         bit [63:0] u;
         longint    res;
         p = 31;
         while (p > 0 && fx[p] == 1'b0) p--;
         m = 64'(fx) << (31 - p);
         frac = '0;
         for (int k = 0; k < LOG_FRAC_BITS; k++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
               frac = frac | 64'd1;
               m = m >> 1;
            end
         end
         lg   = longint'(p - 16) * (longint'(1) << LOG_FRAC_BITS) + longint'(frac);
         prod = lg * longint'(LN2_Q32);
         u    = 64'(prod) + (64'd1 << 39) + (64'd1 << 61);
         res  = longint'(u >> 40) - (longint'(1) << 21);
         return res[20:0];
      endfunction

      function logic [31:0] density_at(longint x);
         int        n;
         longint    t0;
         longint    tl;
         longint    a;
         longint    b;
         bit [65:0] num;
         bit [65:0] d;
         bit [65:0] q;
         n  = active_count();
         t0 = longint'($signed(grid_ticks[0]));
         tl = longint'($signed(grid_ticks[n - 1]));
         if (x <= t0) return grid_dens[0];
         if (x >= tl) return grid_dens[n - 1];
         // search top bin downward, first hit wins
         for (int j = n - 1; j >= 1; j--) begin
            a = longint'($signed(grid_ticks[j - 1]));
            b = longint'($signed(grid_ticks[j]));
            if (x >= a && x < b) begin
               d   = 66'(b - a);
               num = 66'(b - x) * 66'(grid_dens[j - 1]) + 66'(x - a) * 66'(grid_dens[j]);
               q   = (num + d / 2) / d;
               return q[31:0];
            end
         end
         return '0;
      endfunction

      function void note(req_type r);
         rsp_type     e;
         logic [31:0] fx;
         if (r.command == CMD_WRITE) begin
            grid_ticks[r.entry_index] = r.tick_position;
            grid_dens[r.entry_index]  = r.density_value;
            e.log_density = '0;
            e.status      = STATUS_WRITE;
            n_write++;
         end else begin
            fx = density_at(longint'(r.query_position));
            n_query++;
            if (fx == '0) begin
               e.log_density = '0;
               e.status      = STATUS_ZERO;
               n_zero++;
            end else begin
               e.log_density = ln_q16(fx);
               e.status      = STATUS_VALID;
            end
         end
         expected_q = {expected_q, e};
      endfunction

      function void check(rsp_type a);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result log_density=%0d status=%0d",
                     $time, a.log_density, a.status);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (a.log_density !== e.log_density) begin
            $display("%0t: log_density mismatch expected=%0d actual=%0d",
                     $time, e.log_density, a.log_density);
            errors++;
         end
         if (a.status !== e.status) begin
            $display("%0t: status mismatch expected=%0d actual=%0d",
                     $time, e.status, a.status);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_payload;
   logic        csr_write_enable;
   logic [11:0] csr_write_data;

   density_scoreboard sb;
   bit  calm;
   int  cycles;
   int  random_items;
   int  stall_left;

   interpolated_log_density_lookup #(.TABLE_DEPTH(DEPTH)) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result side: check accepted items, stall in random bursts
   initial begin
      rsp_stall  <= 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) sb.check(rsp_payload);
         if (!calm && stall_left == 0 && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 14);
         if (calm) stall_left = 0;
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   task automatic send(req_type r);
      int gap;
      if (!calm && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      sb.note(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_count(logic [11:0] v);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      sb.set_count(v);
      csr_write_enable <= 1'b0;
   endtask

   function automatic req_type make_write(int idx, logic [31:0] t, logic [31:0] d);
      req_type r;
      r.command        = CMD_WRITE;
      r.entry_index    = idx[10:0];
      r.tick_position  = t;
      r.density_value  = d;
      r.query_position = $urandom;
      return r;
   endfunction

   function automatic req_type make_query(logic [31:0] x);
      req_type r;
      r.command        = CMD_QUERY;
      r.entry_index    = 11'($urandom);
      r.tick_position  = $urandom;
      r.density_value  = $urandom;
      r.query_position = x;
      return r;
   endfunction

   function automatic logic [31:0] pick_density();
      case ($urandom_range(0, 15))
         0, 1:    return '0;
         2:       return 32'hFFFF_FFFF;
         3:       return $urandom_range(1, 3);
         default: return $urandom;
      endcase
   endfunction

   // mode 0: sorted over full range, 1: tight ascending steps, 2: unsorted
   task automatic load_table(int n, int mode);
      int     grid[$];
      longint base;
      grid = {};
      base = longint'($signed($urandom)) >>> 1;
      for (int i = 0; i < n; i++) begin
         if (mode == 1) begin
            grid = {grid, int'(base)};
            base += $urandom_range(0, 300);
         end else begin
            grid = {grid, int'($urandom)};
         end
      end
      if (mode == 0) grid.sort();
      for (int i = 0; i < n; i++) send(make_write(i, grid[i], pick_density()));
   endtask

   // large grid: fill the top eight points ascending and copy the lowest into
   // entry 0, so any query reads only entry 0 and the top eight entries
   task automatic load_sparse(int n);
      int     grid[$];
      longint base;
      grid = {};
      base = longint'($signed($urandom)) >>> 1;
      for (int i = 0; i < 8; i++) begin
         grid = {grid, int'(base)};
         base += $urandom_range(0, 1 << 20);
      end
      send(make_write(0, grid[0], pick_density()));
      for (int i = 0; i < 8; i++) send(make_write(n - 8 + i, grid[i], pick_density()));
   endtask

   function automatic logic [31:0] pick_position();
      int     n;
      int     lo;
      int     j;
      longint a;
      longint b;
      n  = sb.active_count();
      lo = (n > 300) ? n - 8 : 0;
      j  = $urandom_range(lo, n - 2);
      a  = longint'($signed(sb.grid_ticks[j]));
      b  = longint'($signed(sb.grid_ticks[j + 1]));
      case ($urandom_range(0, 9))
         0:       return $urandom;
         1:       return 32'h8000_0000;
         2:       return 32'h7FFF_FFFF;
         3, 4:    return 32'(a + $urandom_range(0, 4) - 2);
         default: begin
            if (b - a > 1) return 32'(a + longint'($urandom) % (b - a));
            return 32'(a);
         end
      endcase
   endfunction

   initial begin
      int n;
      int queries;
      int pick;
      sb           = new();
      calm         = 1'b0;
      cycles       = 0;
      random_items = 0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_payload      <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset count of 2000 on a sparse table
      load_sparse(2000);
      send(make_query(32'h8000_0000));
      send(make_query(32'h7FFF_FFFF));
      send(make_query(sb.grid_ticks[0]));
      send(make_query(sb.grid_ticks[1999]));
      send(make_query(sb.grid_ticks[1995] + 32'd1));

      // count above table depth clamps to the depth
      write_count(12'd4095);
      load_sparse(DEPTH);
      send(make_query(sb.grid_ticks[DEPTH - 1]));
      send(make_query(sb.grid_ticks[DEPTH - 2] + 32'd1));

      // count below two clamps to two; zero and full-scale densities
      write_count(12'd0);
      send(make_write(0, 32'hFFFF_0000, 32'd0));
      send(make_write(1, 32'h0001_0000, 32'hFFFF_FFFF));
      send(make_query(32'h0000_0000));
      send(make_query(32'hFFFF_0000));
      write_count(12'd1);
      send(make_query(32'h0001_0000));
      // descending pair: the query lies at or below the first point and takes its density
      send(make_write(0, 32'h0010_0000, 32'h0001_0000));
      send(make_write(1, 32'hFFF0_0000, 32'h0002_0000));
      send(make_query(32'h0000_0000));
      write_count(12'd2);
      send(make_write(0, 32'h0000_0000, 32'h0000_0001));
      send(make_write(1, 32'h0000_0002, 32'h0000_0003));
      send(make_query(32'h0000_0001));

      while (random_items < RANDOM_GOAL) begin
         if (random_items > RANDOM_GOAL * 85 / 100) calm = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 45)      n = $urandom_range(2, 8);
         else if (pick < 80) n = $urandom_range(9, 40);
         else if (pick < 88) n = $urandom_range(0, 1);
         else if (pick < 94) n = $urandom_range(100, 300);
         else                n = $urandom_range(2000, 4095);
         write_count(n[11:0]);
         n = sb.active_count();
         queries = (n > 300) ? 3 : $urandom_range(20, 40);
         if (n <= 300) begin
            pick = $urandom_range(0, 9);
            load_table(n, (pick < 5) ? 0 : (pick < 8) ? 1 : 2);
            random_items += n;
         end else begin
            load_sparse(n);
            random_items += 9;
         end
         for (int q = 0; q < queries; q++) begin
            // occasional stray write into the active grid
            if (n <= 300 && $urandom_range(0, 9) == 0)
               send(make_write($urandom_range(0, n - 1), $urandom, pick_density()));
            else
               send(make_query(pick_position()));
            random_items++;
         end
      end

      drain();
      repeat (100) @(posedge clock);
      $display("covered %0d writes and %0d queries (%0d zero density) over %0d cycles",
               sb.n_write, sb.n_query, sb.n_zero, cycles);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
